>>> hdl/esctr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctr_pkg - shared types and constants for the throttle ramp block
// Field widths, reset values, register indexes and the beat structs passed
// between the block's modules.
// ----------------------------------------------------------------------------
package esctr_pkg;

  localparam int PULSE_W = 11;
  localparam int STEP_W  = 10;
  localparam int IVL_W   = 16;
  localparam int SECS_W  = 16;
  localparam int WD_W    = 26;
  localparam int IDX_W   = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_NEUTRAL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_FWD  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_REV  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_STEP = 3'd3;
  localparam logic [IDX_W-1:0] REG_INTERVAL = 3'd4;

  // reset values
  localparam logic [PULSE_W-1:0] NEUTRAL_RST  = 11'd1500;
  localparam logic [PULSE_W-1:0] MIN_FWD_RST  = 11'd1600;
  localparam logic [PULSE_W-1:0] MIN_REV_RST  = 11'd1400;
  localparam logic [STEP_W-1:0]  MAX_STEP_RST = 10'd12;
  localparam logic [IVL_W-1:0]   INTERVAL_RST = 16'd50;

  // output pulse limits, watchdog scale
  localparam logic [PULSE_W-1:0] PULSE_LOW   = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_HIGH  = 11'd2000;
  localparam logic [WD_W-1:0]    MS_PER_SEC  = 26'd1000;

  // action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_CMD  = 1'b1;

  typedef struct packed {
    logic [PULSE_W-1:0] neutral_pulse;
    logic [PULSE_W-1:0] min_forward_pulse;
    logic [PULSE_W-1:0] min_reverse_pulse;
    logic [STEP_W-1:0]  max_step;
    logic [IVL_W-1:0]   ramp_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [PULSE_W-1:0] target_pulse;
    logic [SECS_W-1:0]  timeout_seconds;
    logic               led_request;
  } item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_out;
    logic               led_out;
    logic               watchdog_fired;
    logic               ramp_stepped;
    logic               watchdog_armed;
  } result_t;

endpackage

>>> hdl/esc_throttle_ramp_with_timeout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_throttle_ramp_with_timeout - slew-limited throttle with watchdog
// Each input beat is a 1 ms tick or a throttle command; each yields one
// result beat carrying the pulse width for the speed controller.
// ----------------------------------------------------------------------------
// Usage: one result beat per input beat, in order. An input beat lands in an
// input register, is processed combinationally against the controller
// state (watchdog check, ramp timer, slew step, deadband, output clamp) and
// the result is held in an output register until taken. Throughput is one
// beat per clock while the output is not stalled; out_valid rises when the
// beat moves from the input register into the output register. in_stall
// rises only when the input register holds a beat and the output register
// is full and stalled. Commands set the target and LED and arm the
// watchdog (timeout_seconds * 1000 ticks) or disarm it when zero. Ticks run
// the watchdog first, then step the tracked pulse every ramp_interval_ms
// ticks by at most max_step. Configuration registers (index 0..4: neutral,
// min forward, min reverse, max step, ramp interval) are always ready and
// should be written while the block is idle; other indexes are ignored.
// ----------------------------------------------------------------------------
module esc_throttle_ramp_with_timeout
  import esctr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [PULSE_W-1:0] in_target_pulse,
  input  logic [SECS_W-1:0]  in_timeout_seconds,
  input  logic               in_led_request,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PULSE_W-1:0] out_pulse_out,
  output logic               out_led_out,
  output logic               out_watchdog_fired,
  output logic               out_ramp_stepped,
  output logic               out_watchdog_armed,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    in_vld_r, in_vld_nxt;
  result_t res;
  result_t res_r, res_nxt;
  logic    out_vld_r, out_vld_nxt;
  logic    advance;   // input register beat moves into the output register
  logic    in_take;   // input beat accepted

  assign cfg_ready = 1'b1;

  esctr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // the output register frees up in the same cycle it is drained
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  esctr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item_en (advance),
    .item    (item_r),
    .res     (res)
  );

  always_comb begin
    item_nxt   = item_r;
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      item_nxt.action          = in_action;
      item_nxt.target_pulse    = in_target_pulse;
      item_nxt.timeout_seconds = in_timeout_seconds;
      item_nxt.led_request     = in_led_request;
      in_vld_nxt               = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r && out_stall;
    if (advance) begin
      res_nxt     = res;
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_pulse_out      = res_r.pulse_out;
  assign out_led_out        = res_r.led_out;
  assign out_watchdog_fired = res_r.watchdog_fired;
  assign out_ramp_stepped   = res_r.ramp_stepped;
  assign out_watchdog_armed = res_r.watchdog_armed;

endmodule

>>> hdl/esctr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctr_cfg - configuration register file
// Five writable registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module esctr_cfg
  import esctr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_index,
  input  logic [31:0]        wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_NEUTRAL:  cfg_nxt.neutral_pulse     = wr_data[PULSE_W-1:0];
        REG_MIN_FWD:  cfg_nxt.min_forward_pulse = wr_data[PULSE_W-1:0];
        REG_MIN_REV:  cfg_nxt.min_reverse_pulse = wr_data[PULSE_W-1:0];
        REG_MAX_STEP: cfg_nxt.max_step          = wr_data[STEP_W-1:0];
        REG_INTERVAL: cfg_nxt.ramp_interval_ms  = wr_data[IVL_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral_pulse     <= NEUTRAL_RST;
      cfg_r.min_forward_pulse <= MIN_FWD_RST;
      cfg_r.min_reverse_pulse <= MIN_REV_RST;
      cfg_r.max_step          <= MAX_STEP_RST;
      cfg_r.ramp_interval_ms  <= INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/esctr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctr_core - watchdog, ramp timer and slew-limited pulse tracker
// Holds the controller state and computes one result per processed beat.
// ----------------------------------------------------------------------------
module esctr_core
  import esctr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_en,
  input  item_t   item,
  output result_t res
);

  logic [PULSE_W-1:0] target_r,  target_nxt;
  logic [PULSE_W-1:0] tracked_r, tracked_nxt;
  logic [PULSE_W-1:0] applied_r, applied_nxt;
  logic [IVL_W-1:0]   ramp_el_r, ramp_el_nxt;
  logic [WD_W-1:0]    wd_lim_r,  wd_lim_nxt;
  logic [WD_W-1:0]    wd_el_r,   wd_el_nxt;
  logic               wd_on_r,   wd_on_nxt;
  logic               led_r,     led_nxt;

  logic [WD_W-1:0]    wd_el_inc;
  logic [IVL_W-1:0]   ramp_el_inc;
  logic               fire;
  logic               step;
  logic [PULSE_W-1:0] tgt;
  logic               up;
  logic               moved;
  logic               fwd;
  logic [PULSE_W-1:0] mag;
  logic [PULSE_W-1:0] delta;
  logic [PULSE_W-1:0] tr_new;
  logic [PULSE_W-1:0] clamped;
  logic               is_cmd;

  assign is_cmd      = (item.action == ACT_CMD);
  assign wd_el_inc   = (wd_el_r != '1) ? wd_el_r + 1'b1 : wd_el_r;
  assign ramp_el_inc = (ramp_el_r != '1) ? ramp_el_r + 1'b1 : ramp_el_r;
  assign fire        = wd_on_r && (wd_el_inc >= wd_lim_r);
  assign step        = (ramp_el_inc >= cfg.ramp_interval_ms);

  // ramp toward the target as it stands after the watchdog check
  assign tgt    = fire ? cfg.neutral_pulse : target_r;
  assign up     = (tgt > tracked_r);
  assign moved  = (tgt != tracked_r);
  assign fwd    = (tgt > cfg.neutral_pulse) ||
                  ((tgt == cfg.neutral_pulse) && (tracked_r > cfg.neutral_pulse));
  assign mag    = up ? (tgt - tracked_r) : (tracked_r - tgt);
  assign delta  = (mag < {1'b0, cfg.max_step}) ? mag : {1'b0, cfg.max_step};
  assign tr_new = up ? (tracked_r + delta) : (tracked_r - delta);

  // deadband; neutral passes unchanged
  always_comb begin
    if (tr_new == cfg.neutral_pulse) begin
      clamped = tr_new;
    end else if (fwd) begin
      clamped = (tr_new < cfg.min_forward_pulse) ? cfg.min_forward_pulse : tr_new;
    end else begin
      clamped = (tr_new > cfg.min_reverse_pulse) ? cfg.min_reverse_pulse : tr_new;
    end
  end

  always_comb begin
    target_nxt  = target_r;
    tracked_nxt = tracked_r;
    applied_nxt = applied_r;
    ramp_el_nxt = ramp_el_r;
    wd_lim_nxt  = wd_lim_r;
    wd_el_nxt   = wd_el_r;
    wd_on_nxt   = wd_on_r;
    led_nxt     = led_r;
    if (is_cmd) begin
      target_nxt = item.target_pulse;
      led_nxt    = item.led_request;
      if (item.timeout_seconds != '0) begin
        wd_lim_nxt = WD_W'(item.timeout_seconds) * MS_PER_SEC;
        wd_el_nxt  = '0;
        wd_on_nxt  = 1'b1;
      end else begin
        wd_on_nxt  = 1'b0;
      end
    end else begin
      wd_el_nxt   = wd_el_inc;
      ramp_el_nxt = ramp_el_inc;
      if (fire) begin
        wd_on_nxt  = 1'b0;
        target_nxt = cfg.neutral_pulse;
        led_nxt    = 1'b0;
      end
      if (step) begin
        ramp_el_nxt = '0;
        if (moved) begin
          tracked_nxt = tr_new;
          applied_nxt = clamped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r  <= NEUTRAL_RST;
      tracked_r <= NEUTRAL_RST;
      applied_r <= NEUTRAL_RST;
      ramp_el_r <= '0;
      wd_lim_r  <= '0;
      wd_el_r   <= '0;
      wd_on_r   <= 1'b0;
      led_r     <= 1'b0;
    end else if (item_en) begin
      target_r  <= target_nxt;
      tracked_r <= tracked_nxt;
      applied_r <= applied_nxt;
      ramp_el_r <= ramp_el_nxt;
      wd_lim_r  <= wd_lim_nxt;
      wd_el_r   <= wd_el_nxt;
      wd_on_r   <= wd_on_nxt;
      led_r     <= led_nxt;
    end
  end

  always_comb begin
    if (applied_nxt < PULSE_LOW) begin
      res.pulse_out = PULSE_LOW;
    end else if (applied_nxt > PULSE_HIGH) begin
      res.pulse_out = PULSE_HIGH;
    end else begin
      res.pulse_out = applied_nxt;
    end
    res.led_out        = led_nxt;
    res.watchdog_fired = !is_cmd && fire;
    res.ramp_stepped   = !is_cmd && step;
    res.watchdog_armed = wd_on_nxt;
  end

endmodule

>>> hdl/esctr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esctr_chk - port-level checks for the throttle ramp block
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module esctr_chk
  import esctr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PULSE_W-1:0] out_pulse_out,
  input logic               out_led_out,
  input logic               out_watchdog_fired,
  input logic               out_watchdog_armed
);

  // output register empties on reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pulse_out)
      && $stable(out_watchdog_fired) && $stable(out_led_out))
    else $error("stalled result beat changed");

  // driven pulse always in the legal window
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pulse_out >= PULSE_LOW) && (out_pulse_out <= PULSE_HIGH))
    else $error("pulse_out out of range");

  // an expiring watchdog disarms itself and turns the LED off
  a_fire: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_watchdog_fired |-> !out_watchdog_armed && !out_led_out)
    else $error("watchdog fired but still armed or LED on");

endmodule

bind esc_throttle_ramp_with_timeout esctr_chk u_esctr_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_pulse_out      (out_pulse_out),
  .out_led_out        (out_led_out),
  .out_watchdog_fired (out_watchdog_fired),
  .out_watchdog_armed (out_watchdog_armed)
);
